// ===== rtl/krt_pkg.sv =====
package krt_pkg;

   // command codes carried on the request channel
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_UPDATE = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_SEARCH = 2'd3
   } krt_action_type;

   // status codes returned on the response channel
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_DUP     = 3'd2,
      ST_MISSING = 3'd3,
      ST_EMPTY   = 3'd4
   } krt_status_type;

   // controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } krt_state_type;

   localparam int DATA_W = 32;
   localparam int SLOT_OUT_W = 7;
   localparam int COUNT_OUT_W = 8;

   // one stored record
   typedef struct packed {
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] quantity;
      logic        [DATA_W-1:0] price;
   } krt_record_type;

   // command token that travels down the chain of cells
   typedef struct packed {
      krt_action_type           action;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] quantity;
      logic        [DATA_W-1:0] price;
      logic                     hit;
      logic signed [DATA_W-1:0] found_quantity;
      logic        [DATA_W-1:0] found_price;
   } krt_token_type;

endpackage

// ===== rtl/krt_ifs.sv =====
interface krt_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  action;
   logic signed [31:0] item_key;
   logic signed [31:0] new_quantity;
   logic        [31:0] new_price;

   modport source (output valid, action, item_key, new_quantity, new_price, input ready);
   modport sink   (input valid, action, item_key, new_quantity, new_price, output ready);
endinterface

interface krt_rsp_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  status;
   logic signed [31:0] found_quantity;
   logic        [31:0] found_price;
   logic        [6:0]  found_slot;
   logic        [7:0]  record_count;

   modport source (output valid, status, found_quantity, found_price, found_slot,
                   record_count, input ready);
   modport sink   (input valid, status, found_quantity, found_price, found_slot,
                   record_count, output ready);
endinterface

// ===== rtl/krt_cell.sv =====
module krt_cell
   import krt_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 7,
   parameter int CNT_W      = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_valid_i,
   input  krt_token_type        tok_i,
   input  logic [IDX_W-1:0]     tok_slot_i,
   input  logic [CNT_W-1:0]     tok_count_i,
   input  krt_record_type       next_rec_i,
   output logic                 tok_valid_o,
   output krt_token_type        tok_o,
   output logic [IDX_W-1:0]     tok_slot_o,
   output logic [CNT_W-1:0]     tok_count_o,
   output krt_record_type       rec_o
);

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_INDEX);
   localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(CELL_INDEX);

   krt_record_type       rec_ff, rec_in;
   logic                 tok_valid_ff;
   krt_token_type        tok_ff, tok_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]     count_ff;

   logic in_range;
   logic match;

   // compare the passing command against the record held here
   always_comb begin
      in_range = tok_count_i > MY_POS;
      match    = tok_valid_i && in_range && !tok_i.hit && (rec_ff.key == tok_i.key);

      rec_in  = rec_ff;
      tok_in  = tok_i;
      slot_in = tok_slot_i;

      if (match) begin
         tok_in.hit = 1'b1;
         slot_in    = MY_SLOT;
      end

      if (tok_valid_i) begin
         case (tok_i.action)
            ACT_INSERT: begin
               // first free slot takes the new record when no duplicate was seen
               if (!tok_i.hit && tok_count_i == MY_POS) begin
                  rec_in.key      = tok_i.key;
                  rec_in.quantity = tok_i.quantity;
                  rec_in.price    = tok_i.price;
               end
            end
            ACT_UPDATE: begin
               if (match) begin
                  rec_in.quantity = tok_i.quantity;
               end
            end
            ACT_DELETE: begin
               // matched slot and every later occupied slot pull in the neighbour record
               if (in_range && (match || tok_i.hit)) begin
                  rec_in = next_rec_i;
               end
            end
            ACT_SEARCH: begin
               if (match) begin
                  tok_in.found_quantity = rec_ff.quantity;
                  tok_in.found_price    = rec_ff.price;
               end
            end
            default: begin
               rec_in = rec_ff;
            end
         endcase
      end
   end

   // record storage and token payload, no reset
   always_ff @(posedge clock) begin
      rec_ff   <= rec_in;
      tok_ff   <= tok_in;
      slot_ff  <= slot_in;
      count_ff <= tok_count_i;
   end

   // token valid travels with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_i;
      end
   end

   assign tok_valid_o = tok_valid_ff;
   assign tok_o       = tok_ff;
   assign tok_slot_o  = slot_ff;
   assign tok_count_o = count_ff;
   assign rec_o       = rec_ff;

endmodule

// ===== rtl/keyed_record_table_core.sv =====
// keyed record table: a packed table of keyed records held in a chain of cells
// request channel (req_bus) carries one command per transaction: insert,
// update quantity, delete or search by key; response channel (rsp_bus)
// returns one transaction per command with status, found quantity, price,
// slot and the record count after the command
// each cell holds one record; a command token walks the chain one cell per
// cycle through every cell register, and the controller then registers the
// response from the chain tail; delete compacts on the fly as each later
// cell copies its upper neighbour while the token passes
// insert into a full table and any other command on an empty table are
// answered from the count alone, in the cycle after acceptance
// one command is in flight at a time: the next request is taken once the
// previous response has been delivered
// a stalled receiver holds the response register steady and blocks requests
// reset empties the table (count to zero); record storage is not cleared
module keyed_record_table_core
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
) (
   input  logic      clock,
   input  logic      reset,
   krt_req_if.sink   req_bus,
   krt_rsp_if.source rsp_bus
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   // chain links
   logic               tok_valid [TABLE_DEPTH+1];
   krt_token_type      tok       [TABLE_DEPTH+1];
   logic [IDX_W-1:0]   tok_slot  [TABLE_DEPTH+1];
   logic [CNT_W-1:0]   tok_count [TABLE_DEPTH+1];
   krt_record_type     rec       [TABLE_DEPTH+1];

   krt_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   krt_status_type     rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_qty_ff, rsp_qty_in;
   logic [31:0]        rsp_price_ff, rsp_price_in;
   logic [IDX_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic               req_fire;
   krt_action_type     req_action;
   krt_token_type      tail;

   // the cell chain
   assign rec[TABLE_DEPTH] = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      krt_cell #(
         .CELL_INDEX (i),
         .IDX_W      (IDX_W),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .tok_valid_i (tok_valid[i]),
         .tok_i       (tok[i]),
         .tok_slot_i  (tok_slot[i]),
         .tok_count_i (tok_count[i]),
         .next_rec_i  (rec[i+1]),
         .tok_valid_o (tok_valid[i+1]),
         .tok_o       (tok[i+1]),
         .tok_slot_o  (tok_slot[i+1]),
         .tok_count_o (tok_count[i+1]),
         .rec_o       (rec[i])
      );
   end

   assign req_bus.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_action    = krt_action_type'(req_bus.action);
   assign tail          = tok[TABLE_DEPTH];

   // token injected at the head of the chain
   always_comb begin
      tok[0].action         = req_action;
      tok[0].key            = req_bus.item_key;
      tok[0].quantity       = req_bus.new_quantity;
      tok[0].price          = req_bus.new_price;
      tok[0].hit            = 1'b0;
      tok[0].found_quantity = '0;
      tok[0].found_price    = '0;
      tok_slot[0]           = '0;
      tok_count[0]          = count_ff;
   end

   // controller: issue, collect, respond
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_price_in  = rsp_price_ff;
      rsp_slot_in   = rsp_slot_ff;
      tok_valid[0]  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_qty_in   = '0;
               rsp_price_in = '0;
               rsp_slot_in  = '0;
               if (req_action == ACT_INSERT && count_ff >= FULL_COUNT) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
               end else if (req_action != ACT_INSERT && count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  tok_valid[0] = 1'b1;
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (tok_valid[TABLE_DEPTH]) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_qty_in   = tail.found_quantity;
               rsp_price_in = tail.found_price;
               rsp_slot_in  = '0;
               if (tail.action == ACT_INSERT) begin
                  if (tail.hit) begin
                     rsp_status_in = ST_DUP;
                  end else begin
                     rsp_status_in = ST_OK;
                     rsp_slot_in   = IDX_W'(count_ff);
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else if (tail.hit) begin
                  rsp_status_in = ST_OK;
                  rsp_slot_in   = tok_slot[TABLE_DEPTH];
                  if (tail.action == ACT_DELETE) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end else begin
                  rsp_status_in = ST_MISSING;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_price_ff  <= rsp_price_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.found_quantity = rsp_qty_ff;
   assign rsp_bus.found_price    = rsp_price_ff;
   assign rsp_bus.found_slot     = SLOT_OUT_W'(rsp_slot_ff);
   assign rsp_bus.record_count   = COUNT_OUT_W'(count_ff);

endmodule

// ===== sim/tb_keyed_record_table_core.sv =====
`timescale 1ns / 1ps

module tb_keyed_record_table_core;
   import krt_pkg::*;

   localparam int TABLE_DEPTH    = 128;
   localparam int RANDOM_ITEMS   = 1400;
   localparam int KEY_POOL_SIZE  = 192;
   localparam int ROUND_ITEMS    = 600;
   localparam int FILL_ITEMS     = 250;
   localparam int CHURN_ITEMS    = 130;
   localparam int PRESSURE_AT    = 350;
   localparam int LONG_HOLD      = 1500;
   localparam int SETTLE_CYCLES  = 2 * (TABLE_DEPTH + 3);
   localparam int CYCLE_LIMIT    = 1_500_000;

   localparam logic signed [31:0] KEY_MIN   = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] KEY_ODD   = 32'sh5A5A_A5A5;
   localparam logic        [31:0] PRICE_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_t;

   typedef struct {
      krt_status_type     status;
      logic signed [31:0] quantity;
      logic        [31:0] price;
      logic        [6:0]  slot;
      logic        [7:0]  count;
   } table_reply_t;

   typedef struct {
      krt_action_type     action;
      logic signed [31:0] key;
      logic signed [31:0] quantity;
      logic        [31:0] price;
      bit                 typed;
      table_reply_t       reply;
   } command_row_t;

   logic clock;
   logic reset;

   krt_req_if req_bus ();
   krt_rsp_if rsp_bus ();

   keyed_record_table_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // shadow copy of the table, kept packed in insertion order
   logic signed [31:0] held_key      [TABLE_DEPTH];
   logic signed [31:0] held_quantity [TABLE_DEPTH];
   logic        [31:0] held_price    [TABLE_DEPTH];
   int                 held_records;

   table_reply_t       expected_replies [$];
   command_row_t       directed_rows [$];
   logic signed [31:0] key_pool [KEY_POOL_SIZE];
   idle_mode_t         idle_mode;
   int                 accepted_count;
   int                 error_count;
   int                 cycle_count;
   table_reply_t       want;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle probability in percent for either side of the current phase
   function automatic int idle_pct(bit receiver_side);
      case (idle_mode)
         IDLE_SENDER:   return receiver_side ? 0 : 54;
         IDLE_RECEIVER: return receiver_side ? 54 : 0;
         IDLE_BOTH:     return 37;
         default:       return 0;
      endcase
   endfunction

   // applies one command to the shadow table and returns the reply it gives
   function automatic table_reply_t apply_command(command_row_t cmd);
      table_reply_t r;
      int hit;
      r.status   = ST_OK;
      r.quantity = '0;
      r.price    = '0;
      r.slot     = '0;
      hit = held_records;
      for (int s = held_records - 1; s >= 0; s--) begin
         if (held_key[s] == cmd.key) hit = s;
      end
      if (cmd.action == ACT_INSERT) begin
         if (held_records >= TABLE_DEPTH) begin
            r.status = ST_FULL;
         end else if (hit < held_records) begin
            r.status = ST_DUP;
         end else begin
            held_key[held_records]      = cmd.key;
            held_quantity[held_records] = cmd.quantity;
            held_price[held_records]    = cmd.price;
            r.slot = 7'(held_records);
            held_records++;
         end
      end else if (held_records == 0) begin
         r.status = ST_EMPTY;
      end else if (hit == held_records) begin
         r.status = ST_MISSING;
      end else begin
         r.slot = 7'(hit);
         case (cmd.action)
            ACT_UPDATE: begin
               held_quantity[hit] = cmd.quantity;
            end
            ACT_DELETE: begin
               // later records close the gap
               for (int s = hit; s < held_records - 1; s++) begin
                  held_key[s]      = held_key[s + 1];
                  held_quantity[s] = held_quantity[s + 1];
                  held_price[s]    = held_price[s + 1];
               end
               held_records--;
            end
            default: begin
               r.quantity = held_quantity[hit];
               r.price    = held_price[hit];
            end
         endcase
      end
      r.count = 8'(held_records);
      return r;
   endfunction

   // one line of the directed table; the reply is only used when typed is set
   task automatic add_row(krt_action_type act, logic signed [31:0] key,
                          logic signed [31:0] qty, logic [31:0] price, bit typed,
                          krt_status_type st, logic signed [31:0] fq,
                          logic [31:0] fp, int slot, int count);
      command_row_t row;
      row.action         = act;
      row.key            = key;
      row.quantity       = qty;
      row.price          = price;
      row.typed          = typed;
      row.reply.status   = st;
      row.reply.quantity = fq;
      row.reply.price    = fp;
      row.reply.slot     = 7'(slot);
      row.reply.count    = 8'(count);
      directed_rows.push_back(row);
   endtask

   // offers one command and books its reply once the transaction is taken
   task automatic issue_command(command_row_t cmd);
      table_reply_t predicted;
      while ($urandom_range(99) < idle_pct(1'b0)) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= cmd.action;
      req_bus.item_key     <= cmd.key;
      req_bus.new_quantity <= cmd.quantity;
      req_bus.new_price    <= cmd.price;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = apply_command(cmd);
      expected_replies.push_back(cmd.typed ? cmd.reply : predicted);
      accepted_count <= accepted_count + 1;
   endtask

   // response side: random stalls plus one long hold-off to back up the input
   initial begin : receiver
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && accepted_count == PRESSURE_AT) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= idle_pct(1'b1));
         end
      end
   end

   // compare each response transaction with the oldest booked reply
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_replies.size() == 0) begin
            $display("%0t unexpected response: status %0d slot %0d count %0d", $time,
                     rsp_bus.status, rsp_bus.found_slot, rsp_bus.record_count);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.found_quantity !== want.quantity ||
                rsp_bus.found_price !== want.price || rsp_bus.found_slot !== want.slot ||
                rsp_bus.record_count !== want.count) begin
               $display("%0t mismatch: expected status %0d qty %0d price %0d slot %0d count %0d",
                        $time, want.status, want.quantity, want.price, want.slot, want.count);
               $display("%0t          got      status %0d qty %0d price %0d slot %0d count %0d",
                        $time, rsp_bus.status, rsp_bus.found_quantity, rsp_bus.found_price,
                        rsp_bus.found_slot, rsp_bus.record_count);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_keyed_record_table_core: errors");
         $finish;
      end
   end

   // stimulus
   initial begin : stimulus
      command_row_t cmd;
      int           round_pos;
      int           insert_pct;
      int           delete_pct;
      int           roll;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_INSERT;
      req_bus.item_key     = '0;
      req_bus.new_quantity = '0;
      req_bus.new_price    = '0;
      idle_mode            = IDLE_NONE;
      accepted_count       = 0;
      error_count          = 0;
      cycle_count          = 0;
      held_records         = 0;

      // key pool for random traffic, extremes included
      for (int k = 0; k < KEY_POOL_SIZE; k++) key_pool[k] = $urandom;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = -32'sd1;

      // directed table
      add_row(ACT_SEARCH, KEY_MAX, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0);
      add_row(ACT_UPDATE, KEY_MIN, 5, 0, 1, ST_EMPTY, 0, 0, 0, 0);
      add_row(ACT_DELETE, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0);
      add_row(ACT_INSERT, KEY_MIN, KEY_MIN, 0, 1, ST_OK, 0, 0, 0, 1);
      add_row(ACT_INSERT, KEY_MAX, KEY_MAX, PRICE_MAX, 1, ST_OK, 0, 0, 1, 2);
      add_row(ACT_INSERT, 0, 0, 0, 1, ST_OK, 0, 0, 2, 3);
      add_row(ACT_INSERT, KEY_MIN, 7, 7, 1, ST_DUP, 0, 0, 0, 3);
      add_row(ACT_SEARCH, KEY_MAX, 0, 0, 1, ST_OK, KEY_MAX, PRICE_MAX, 1, 3);
      add_row(ACT_SEARCH, -1, 0, 0, 1, ST_MISSING, 0, 0, 0, 3);
      add_row(ACT_UPDATE, -1, 9, 0, 1, ST_MISSING, 0, 0, 0, 3);
      add_row(ACT_DELETE, -1, 0, 0, 1, ST_MISSING, 0, 0, 0, 3);
      add_row(ACT_UPDATE, KEY_MIN, -1, 0, 1, ST_OK, 0, 0, 0, 3);
      add_row(ACT_SEARCH, KEY_MIN, 0, 0, 1, ST_OK, -1, 0, 0, 3);
      add_row(ACT_DELETE, KEY_MIN, 0, 0, 1, ST_OK, 0, 0, 0, 2);
      add_row(ACT_SEARCH, KEY_MAX, 0, 0, 0, ST_OK, 0, 0, 0, 0);
      add_row(ACT_SEARCH, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0);
      add_row(ACT_DELETE, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0);
      add_row(ACT_INSERT, KEY_ODD, 32'sh1234_5678, 32'h8765_4321, 0, ST_OK, 0, 0, 0, 0);
      add_row(ACT_DELETE, KEY_MAX, 0, 0, 0, ST_OK, 0, 0, 0, 0);
      add_row(ACT_SEARCH, KEY_ODD, 0, 0, 0, ST_OK, 0, 0, 0, 0);
      add_row(ACT_DELETE, KEY_ODD, 0, 0, 0, ST_OK, 0, 0, 0, 0);
      add_row(ACT_SEARCH, KEY_ODD, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) issue_command(directed_rows[r]);

      // random rounds: fill towards full, churn, then drain towards empty
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) idle_mode <= idle_mode_t'((i / 100) % 4);
         round_pos = i % ROUND_ITEMS;
         if (round_pos < FILL_ITEMS) begin
            insert_pct = 85;
            delete_pct = 5;
         end else if (round_pos < FILL_ITEMS + CHURN_ITEMS) begin
            insert_pct = 35;
            delete_pct = 25;
         end else begin
            insert_pct = 5;
            delete_pct = 75;
         end
         roll = $urandom_range(99);
         if (roll < insert_pct) begin
            cmd.action = ACT_INSERT;
         end else if (roll < insert_pct + delete_pct) begin
            cmd.action = ACT_DELETE;
         end else begin
            cmd.action = ($urandom_range(1) == 0) ? ACT_UPDATE : ACT_SEARCH;
         end
         // mostly held keys for lookups, pool keys for inserts, a few wild keys
         roll = $urandom_range(99);
         if (roll < 5) begin
            cmd.key = $urandom;
         end else if (cmd.action != ACT_INSERT && held_records > 0 && roll < 85) begin
            cmd.key = held_key[$urandom_range(held_records - 1)];
         end else begin
            cmd.key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
         end
         cmd.quantity = $urandom;
         cmd.price    = $urandom;
         cmd.typed    = 1'b0;
         issue_command(cmd);
      end

      // drain and let the block settle
      req_bus.valid <= 1'b0;
      idle_mode     <= IDLE_NONE;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_keyed_record_table_core: clean");
      end else begin
         $display("tb_keyed_record_table_core: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/krt_pkg.sv
rtl/krt_ifs.sv
rtl/krt_cell.sv
rtl/keyed_record_table_core.sv
sim/tb_keyed_record_table_core.sv
